[rtl/arpc_pkg.sv]
// Shared types and codes for the ARP cache and responder.
// No dependencies; imported by arpc_cell and arp_cache_responder.
package arpc_pkg;

  localparam int IpW  = 32;
  localparam int MacW = 48;
  localparam int OpW  = 16;
  localparam int StW  = 3;

  // Item commands
  localparam logic [1:0] CMD_RX_FRAME = 2'd0;
  localparam logic [1:0] CMD_INSERT   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;
  localparam logic [1:0] CMD_RESOLVE  = 2'd3;

  // ARP opcodes
  localparam logic [OpW-1:0] OPC_REQUEST = 16'd1;
  localparam logic [OpW-1:0] OPC_REPLY   = 16'd2;

  localparam logic [MacW-1:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  // Result status
  localparam logic [StW-1:0] ST_DONE      = 3'd0;
  localparam logic [StW-1:0] ST_REPLY     = 3'd1;
  localparam logic [StW-1:0] ST_REQUEST   = 3'd2;
  localparam logic [StW-1:0] ST_HIT       = 3'd3;
  localparam logic [StW-1:0] ST_MISS      = 3'd4;
  localparam logic [StW-1:0] ST_IGNORED   = 3'd5;
  localparam logic [StW-1:0] ST_REJECTED  = 3'd6;

  // Search token passed down the cell chain
  typedef struct packed {
    logic            valid;
    logic [IpW-1:0]  key;
    logic            found;
    logic [MacW-1:0] hw;
    logic            pub;
  } arpc_tok_t;

endpackage

[rtl/arpc_cell.sv]
// One cache entry of the cell chain: holds IP, MAC and publish flag and
// forwards the search token to the next lower cell. Depends on arpc_pkg.
module arpc_cell import arpc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IpW-1:0]  wr_ip_i,
  input  logic [MacW-1:0] wr_hw_i,
  input  logic            wr_pub_i,
  input  arpc_tok_t       tok_i,
  output arpc_tok_t       tok_o
);

  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] hw_q;
  logic            pub_q;
  arpc_tok_t       tok_d, tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q  <= '0;
      hw_q  <= '0;
      pub_q <= 1'b0;
    end else if (wr_en_i) begin
      ip_q  <= wr_ip_i;
      hw_q  <= wr_hw_i;
      pub_q <= wr_pub_i;
    end
  end

  // first match on the way down wins, so later cells leave it alone
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && (ip_q == tok_i.key)) begin
      tok_d.found = 1'b1;
      tok_d.hw    = hw_q;
      tok_d.pub   = pub_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[rtl/arp_cache_responder.sv]
// ARP cache and responder top level: APB register port, control sequencer
// and the chain of arpc_cell entries. Depends on arpc_pkg and arpc_cell.
//
// The cache is a row of CACHE_ENTRIES cells, one entry each, cleared to zero
// at reset (IP 0 therefore matches an empty entry). An accepted item that
// searches the cache (received request, lookup, resolve) is launched as a
// token into the highest entry, is registered by each cell as it walks down,
// has its outcome taken off the end of the chain (entry 0) and then has its
// result formed, which waits until the output register is free. Received
// replies and static inserts with a nonzero IP write the entry at the
// cursor on acceptance; they, like every item that needs no search, go
// straight to forming the result. A new item is taken in the cycle after
// the previous result has been moved to the output register, which holds
// it until the receiver stops stalling. my_mac lies at byte address 0 and
// my_ip at 8 on the 64-bit register port.
module arp_cache_responder import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // register port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output logic            pready,
  // input items
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      cmd_i,
  input  logic [OpW-1:0]  arp_op_i,
  input  logic [MacW-1:0] sender_mac_i,
  input  logic [IpW-1:0]  sender_ip_i,
  input  logic [IpW-1:0]  target_ip_i,
  input  logic [MacW-1:0] entry_mac_i,
  input  logic            publish_i,
  // result items
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [StW-1:0]  status_o,
  output logic [MacW-1:0] hit_mac_o,
  output logic [MacW-1:0] out_dest_mac_o,
  output logic [OpW-1:0]  out_op_o,
  output logic [MacW-1:0] out_sender_mac_o,
  output logic [IpW-1:0]  out_sender_ip_o,
  output logic [MacW-1:0] out_target_mac_o,
  output logic [IpW-1:0]  out_target_ip_o
);

  localparam int CurW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CurW-1:0] CurTop  = CurW'(CACHE_ENTRIES);
  localparam logic [CurW-1:0] CurLast = CurW'(CACHE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  localparam logic REG_MY_MAC = 1'b0;
  localparam logic REG_MY_IP  = 1'b1;

  // ------------------------------------------------------------------
  // registers
  logic [MacW-1:0] my_mac_q;
  logic [IpW-1:0]  my_ip_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_mac_q <= '0;
      my_ip_q  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_MY_MAC: my_mac_q <= pwdata[MacW-1:0];
        REG_MY_IP:  my_ip_q  <= pwdata[IpW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_MY_MAC: prdata = {16'b0, my_mac_q};
      REG_MY_IP:  prdata = {32'b0, my_ip_q};
      default:    prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // control
  logic [1:0]      state_q, state_d;
  logic            in_acc;
  logic            out_free;
  logic            load_out;
  logic            needs_search;
  logic            wr_en;
  logic [CurW-1:0] cursor_q, cursor_nx;

  logic [1:0]      cmd_q;
  logic [OpW-1:0]  op_q;
  logic [MacW-1:0] smac_q;
  logic [IpW-1:0]  tip_q;
  logic            found_q;
  logic [MacW-1:0] fhw_q;
  logic            fpub_q;

  arpc_tok_t launch_tok;
  arpc_tok_t link [CACHE_ENTRIES+1];
  logic [CACHE_ENTRIES-1:0] cell_wr;
  logic [CACHE_ENTRIES:0]   link_valid;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign load_out   = (state_q == S_RESULT) && out_free;

  assign needs_search = (cmd_i == CMD_LOOKUP) || (cmd_i == CMD_RESOLVE) ||
                        ((cmd_i == CMD_RX_FRAME) && (arp_op_i == OPC_REQUEST));

  assign wr_en = in_acc &&
                 (((cmd_i == CMD_RX_FRAME) && (arp_op_i == OPC_REPLY)) ||
                  ((cmd_i == CMD_INSERT) && (target_ip_i != '0)));

  // cursor steps down before the write and wraps to the top entry
  assign cursor_nx = ((cursor_q == '0) || (cursor_q > CurTop)) ? CurLast
                                                               : cursor_q - 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = needs_search ? S_LAUNCH : S_RESULT;
      S_LAUNCH: state_d = S_SCAN;
      S_SCAN:   if (link[0].valid) state_d = S_RESULT;
      S_RESULT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cursor_q <= CurTop;
    end else begin
      state_q <= state_d;
      if (wr_en) cursor_q <= cursor_nx;
    end
  end

  // hold the item fields needed after acceptance
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_i;
      op_q   <= arp_op_i;
      smac_q <= sender_mac_i;
      tip_q  <= target_ip_i;
    end
    if ((state_q == S_SCAN) && link[0].valid) begin
      found_q <= link[0].found;
      fhw_q   <= link[0].hw;
      fpub_q  <= link[0].pub;
    end
  end

  // ------------------------------------------------------------------
  // cell chain: token enters at the highest entry and leaves at entry 0
  always_comb begin
    launch_tok       = '0;
    launch_tok.valid = (state_q == S_LAUNCH);
    launch_tok.key   = tip_q;
  end

  assign link[CACHE_ENTRIES] = launch_tok;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    assign cell_wr[i] = wr_en && (cursor_nx == CurW'(i));

    arpc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (cell_wr[i]),
      .wr_ip_i  ((cmd_i == CMD_INSERT) ? target_ip_i : sender_ip_i),
      .wr_hw_i  ((cmd_i == CMD_INSERT) ? entry_mac_i : sender_mac_i),
      .wr_pub_i ((cmd_i == CMD_INSERT) && publish_i),
      .tok_i    (link[i+1]),
      .tok_o    (link[i])
    );
  end

  for (genvar i = 0; i <= CACHE_ENTRIES; i++) begin : g_lv
    assign link_valid[i] = link[i].valid;
  end

  // ------------------------------------------------------------------
  // result
  logic [StW-1:0]  res_status;
  logic [MacW-1:0] res_hit_mac, res_dest_mac, res_sender_mac, res_target_mac;
  logic [OpW-1:0]  res_op;
  logic [IpW-1:0]  res_sender_ip, res_target_ip;

  always_comb begin
    res_status     = ST_DONE;
    res_hit_mac    = '0;
    res_dest_mac   = '0;
    res_op         = '0;
    res_sender_mac = '0;
    res_sender_ip  = '0;
    res_target_mac = '0;
    res_target_ip  = '0;
    case (cmd_q)
      CMD_RX_FRAME: begin
        if (op_q == OPC_REPLY) begin
          res_status = ST_DONE;
        end else if ((op_q == OPC_REQUEST) && found_q && fpub_q) begin
          res_status     = ST_REPLY;
          res_dest_mac   = smac_q;
          res_op         = OPC_REPLY;
          res_sender_mac = fhw_q;
          res_sender_ip  = tip_q;
          res_target_mac = my_mac_q;
          res_target_ip  = my_ip_q;
        end else begin
          res_status = ST_IGNORED;
        end
      end
      CMD_INSERT: begin
        res_status = (tip_q == '0) ? ST_REJECTED : ST_DONE;
      end
      default: begin
        if (found_q) begin
          res_status  = ST_HIT;
          res_hit_mac = fhw_q;
        end else if (cmd_q == CMD_LOOKUP) begin
          res_status = ST_MISS;
        end else begin
          res_status     = ST_REQUEST;
          res_dest_mac   = MAC_BCAST;
          res_op         = OPC_REQUEST;
          res_sender_mac = my_mac_q;
          res_sender_ip  = my_ip_q;
          res_target_ip  = tip_q;
        end
      end
    endcase
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o         <= res_status;
      hit_mac_o        <= res_hit_mac;
      out_dest_mac_o   <= res_dest_mac;
      out_op_o         <= res_op;
      out_sender_mac_o <= res_sender_mac;
      out_sender_ip_o  <= res_sender_ip;
      out_target_mac_o <= res_target_mac;
      out_target_ip_o  <= res_target_ip;
    end
  end

  assign out_valid_o = out_valid_q;

  // ------------------------------------------------------------------
`ifndef SYNTH
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(link_valid))
    else $error("more than one search token in the cell chain");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[0].valid |-> (state_q == S_SCAN))
    else $error("search token left the chain outside a scan");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_wr))
    else $error("more than one cell written in a cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(wr_en) |-> (cursor_q < CurTop))
    else $error("replace cursor out of range after a write");
`endif

endmodule
